@@ rtl/vlpd_pkg.sv @@
// Shared types and constants for the varint length-prefix deframer.
// Depends on nothing; imported by vlpd_parser and the top level.
package vlpd_pkg;

    // Stream byte and length widths.
    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 32;
    localparam int unsigned GroupW  = 7;
    // A varint length carries at most five groups; index 4 is the last.
    localparam int unsigned GrpIdxW = 3;
    localparam logic [GrpIdxW-1:0] LastGroup = 3'd4;

    localparam logic [LenW-1:0] DefaultMaxLen = 32'(2 * 1024 * 1024);

    // Parser phases.
    typedef enum logic [1:0] {
        PH_VERSION = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_BODY    = 2'd2,
        PH_HALTED  = 2'd3
    } t_phase;

    // Result kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_VERSION = 2'd1;
    localparam t_kind KIND_ERROR   = 2'd2;

    // Error codes.
    typedef logic t_err;
    localparam t_err ERR_TOO_LARGE  = 1'b0;
    localparam t_err ERR_BAD_VARINT = 1'b1;

    // One result request from the parser to the output register.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [ByteW-1:0] data;
        logic             eom;
        t_err             err;
    } t_result;

endpackage

@@ rtl/vlpd_parser.sv @@
// Phase state machine and length/body counters of the deframer.
// Depends on vlpd_pkg; produces one optional result per accepted byte.
module vlpd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [vlpd_pkg::ByteW-1:0]   i_byte,
    input  logic [vlpd_pkg::LenW-1:0]    i_max_len,
    output vlpd_pkg::t_result            o_result
);
    import vlpd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [LenW-1:0]     r_acc, n_acc;
    logic [GrpIdxW-1:0]  r_grp, n_grp;
    logic [LenW-1:0]     r_rem, n_rem;

    logic [GroupW-1:0]   group;
    logic                cont;
    logic [LenW-1:0]     placed;
    logic [LenW-1:0]     merged;
    logic                too_large;
    logic                bad_varint;
    logic                last_body;

    assign group = i_byte[GroupW-1:0];
    assign cont  = i_byte[ByteW-1];

    // Place the seven-bit group at its position; the fifth group loses its top bits.
    always_comb begin
        unique case (r_grp)
            3'd0:    placed = {25'd0, group};
            3'd1:    placed = {18'd0, group, 7'd0};
            3'd2:    placed = {11'd0, group, 14'd0};
            3'd3:    placed = {4'd0, group, 21'd0};
            3'd4:    placed = {group[3:0], 28'd0};
            default: placed = '0;
        endcase
    end

    assign merged     = r_acc | placed;
    assign too_large  = !cont && (merged > i_max_len);
    assign bad_varint = cont && (r_grp == LastGroup);
    assign last_body  = (r_rem == 32'd1);

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_grp   = r_grp;
        n_rem   = r_rem;
        if (i_accept) begin
            unique case (r_phase)
                PH_VERSION: begin
                    n_phase = PH_LENGTH;
                    n_acc   = '0;
                    n_grp   = '0;
                end
                PH_LENGTH: begin
                    n_acc = merged;
                    n_grp = r_grp + 3'd1;
                    priority if (too_large || bad_varint) begin
                        n_phase = PH_HALTED;
                    end else if (cont) begin
                        n_phase = PH_LENGTH;
                    end else if (merged == '0) begin
                        // Empty message: start on the next length at once.
                        n_acc = '0;
                        n_grp = '0;
                    end else begin
                        n_rem   = merged;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_rem = r_rem - 32'd1;
                    if (last_body) begin
                        n_phase = PH_LENGTH;
                        n_acc   = '0;
                        n_grp   = '0;
                    end
                end
                PH_HALTED: begin
                    n_phase = PH_HALTED;
                end
                default: n_phase = PH_HALTED;
            endcase
        end
    end

    // Result for the byte on the input.
    always_comb begin
        o_result = '0;
        unique case (r_phase)
            PH_VERSION: begin
                o_result.valid = 1'b1;
                o_result.kind  = KIND_VERSION;
                o_result.data  = i_byte;
            end
            PH_LENGTH: begin
                if (too_large || bad_varint) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_ERROR;
                    o_result.err   = too_large ? ERR_TOO_LARGE : ERR_BAD_VARINT;
                end
            end
            PH_BODY: begin
                o_result.valid = 1'b1;
                o_result.kind  = KIND_PAYLOAD;
                o_result.data  = i_byte;
                o_result.eom   = last_body;
            end
            PH_HALTED: begin
                o_result.valid = 1'b0;
            end
            default: o_result = '0;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERSION;
            r_acc   <= '0;
            r_grp   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_grp   <= n_grp;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ rtl/varint_length_prefix_deframer_top.sv @@
// Top level of the varint length-prefix deframer: stream ports, limit register,
// output register. Depends on vlpd_pkg and vlpd_parser.
//
// The block takes one stream byte per cycle and answers each with at most one
// item in the cycle after: the first byte after reset comes out as a version item,
// then each message is a little-endian base-128 length followed by that many
// payload bytes, the last one flagged on tlast. A zero length produces nothing.
// A length above the limit register, or a length whose fifth byte still has its
// continuation bit set, produces one error item and the block then drops all
// input until reset. The only stall comes from the single output register,
// which frees as soon as the downstream side takes it.
// Write the limit register only while no traffic is in flight.
module varint_length_prefix_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Limit register write.
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,      // max_message_length
    // Byte stream in.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,     // [7:0] stream_byte
    // Items out.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,     // [7:0] item_byte
    output logic        o_m_axis_tlast,     // end_of_message
    output logic [2:0]  o_m_axis_tuser      // [1:0] item_kind, [2] length error type
);
    import vlpd_pkg::*;

    logic [LenW-1:0] r_max_len;
    logic            r_out_valid;
    t_kind           r_kind;
    logic [ByteW-1:0] r_data;
    logic            r_eom;
    t_err            r_err;
    logic            in_accept;
    t_result         result;

    // Accept whenever the output register is empty or being emptied.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= DefaultMaxLen;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    vlpd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_byte    (i_s_axis_tdata),
        .i_max_len (r_max_len),
        .o_result  (result)
    );

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= result.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept && result.valid) begin
            r_kind <= result.kind;
            r_data <= result.data;
            r_eom  <= result.eom;
            r_err  <= result.err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_eom;
    assign o_m_axis_tuser  = {r_err, r_kind};

    // End of message is only ever flagged on a payload byte.
    a_eom_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser[1:0] == KIND_PAYLOAD))
        else $error("end of message on a non-payload item");

    // Error items carry a zero byte.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1:0] == KIND_ERROR) |-> (o_m_axis_tdata == '0))
        else $error("error item with nonzero byte");

    // Once an error item is taken the block stays silent.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[1:0] == KIND_ERROR)
        |=> !o_m_axis_tvalid)
        else $error("item produced after an error");

    // Every item carries one of the three defined kinds.
    a_no_kind3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[1:0] == KIND_PAYLOAD ||
                             o_m_axis_tuser[1:0] == KIND_VERSION ||
                             o_m_axis_tuser[1:0] == KIND_ERROR))
        else $error("undefined item kind");

endmodule
